// ===== rtl/ghsoc_pkg.sv =====
package ghsoc_pkg;

   localparam logic [1:0] REQ_LOAD     = 2'd0;
   localparam logic [1:0] REQ_CLASSIFY = 2'd1;
   localparam logic [1:0] REQ_CLEAR    = 2'd2;

   localparam logic CSR_CELL_SIZE = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   localparam int CsrIndexWidth = 8;
   localparam int CfgWidth      = 14;
   localparam int CoordWidth    = 16;
   localparam int CountWidth    = 20;
   localparam logic [CountWidth-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [1:0]             req_type;
      logic signed [15:0]     point_x;
      logic signed [15:0]     point_y;
      logic signed [15:0]     point_z;
   } req_payload_type;

   typedef struct packed {
      logic                   is_obstacle;
      logic signed [15:0]     out_x;
      logic signed [15:0]     out_y;
      logic signed [15:0]     out_z;
      logic [19:0]            obstacle_total;
   } rsp_payload_type;

   // Command handed from the binning front end to the grid back end.
   typedef struct packed {
      logic [1:0]             req_type;
      logic                   in_grid;
      logic signed [15:0]     point_x;
      logic signed [15:0]     point_y;
      logic signed [15:0]     point_z;
   } cmd_base_type;

endpackage

// ===== rtl/grid_height_spread_obstacle_classifier_core.sv =====
// Grid height-spread obstacle classifier. Points are binned into a GRID_DIM x
// GRID_DIM grid on x and z; load beats keep per-cell minimum and maximum
// height, classify beats return one result flagging a spread above the
// threshold with a saturating obstacle count, clear beats start a new frame.
// The front end handles a load or classify beat with two serial 17-step
// divisions by the cell size, each followed by a step that forms the grid
// index, and takes no new beat until it has handed the last one on. The back
// end does a read-modify-write of the cell store for a load and a read, an
// evaluation and a response for a classify. Every 255th clear sweeps the
// store, one entry at a time (GRID_DIM*GRID_DIM entries for a power-of-two
// GRID_DIM); the same sweep runs after reset, and the back end carries out no
// beat until it ends.
module grid_height_spread_obstacle_classifier_core
   import ghsoc_pkg::*;
#(
   parameter int GRID_DIM = 512
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [CfgWidth-1:0]       csr_data
);

   localparam int IdxWidth = $clog2(GRID_DIM);
   localparam int QWidth   = $bits(cmd_base_type) + 2 * IdxWidth;

   logic [CfgWidth-1:0]   edge_len_ff, threshold_ff;
   logic                  f_valid, f_ready, b_valid, b_ready;
   cmd_base_type          f_base;
   logic [2*IdxWidth-1:0] f_cell;
   logic [QWidth-1:0]     b_word;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_len_ff  <= CfgWidth'(100);
         threshold_ff <= CfgWidth'(100);
      end else if (csr_valid && csr_index[CsrIndexWidth-1:1] == '0) begin
         if (csr_index[0] == CSR_CELL_SIZE) edge_len_ff <= csr_data;
         if (csr_index[0] == CSR_THRESHOLD) threshold_ff <= csr_data;
      end
   end

   ghsoc_front #(.GRID_DIM(GRID_DIM)) u_front (
      .clock, .reset, .edge_len(edge_len_ff),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_base(f_base), .cmd_cell(f_cell)
   );

   ghsoc_queue #(.Width(QWidth)) u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data({f_base, f_cell}),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_word)
   );

   ghsoc_back #(.GRID_DIM(GRID_DIM)) u_back (
      .clock, .reset, .threshold(threshold_ff),
      .cmd_valid(b_valid), .cmd_ready(b_ready),
      .cmd_base(b_word[QWidth-1:2*IdxWidth]), .cmd_cell(b_word[2*IdxWidth-1:0]),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data)
   );

endmodule

// ===== rtl/ghsoc_front.sv =====
module ghsoc_front
   import ghsoc_pkg::*;
#(
   parameter int GRID_DIM = 512,
   parameter int IdxWidth = $clog2(GRID_DIM)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CfgWidth-1:0]   edge_len,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  req_payload_type       in_data,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output cmd_base_type          cmd_base,
   output logic [2*IdxWidth-1:0] cmd_cell
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;
   localparam int  QW       = 17;
   localparam int  CntWidth = $clog2(QW + 1);
   localparam logic signed [QW+1:0] HalfDim = (QW+2)'(GRID_DIM / 2);
   localparam logic signed [QW+1:0] DimS    = (QW+2)'(GRID_DIM);

   logic [1:0]           state_ff, state_in;
   req_payload_type      item_ff, item_in;
   logic                 axis_ff, axis_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic [QW-1:0]        quot_ff, quot_in;
   logic [CfgWidth:0]    rem_ff, rem_in;
   logic [CfgWidth-1:0]  div_ff, div_in;
   logic                 neg_ff, neg_in;
   logic [IdxWidth-1:0]  ix_ff, ix_in;
   logic                 ok_ff, ok_in;
   logic [IdxWidth-1:0]  iz_ff, iz_in;

   logic [QW-1:0]        mag;
   logic [CfgWidth:0]    trial;
   logic                 take;
   logic signed [QW+1:0] fq;
   logic signed [QW+1:0] idx;
   logic                 idx_ok;
   logic [IdxWidth-1:0]  idx_bits;
   logic signed [15:0]   coord;

   assign in_ready  = (state_ff == ST_IDLE);
   assign cmd_valid = (state_ff == ST_OUT);
   assign cmd_base  = '{req_type: item_ff.req_type, in_grid: ok_ff,
                        point_x: item_ff.point_x, point_y: item_ff.point_y,
                        point_z: item_ff.point_z};
   assign cmd_cell  = {ix_ff, iz_ff};

   // Magnitude of the coordinate of the current axis.
   assign coord = axis_ff ? item_ff.point_z : item_ff.point_x;
   assign mag   = coord[15] ? QW'(-32'(coord)) : QW'(coord);

   // One restoring step of the unsigned divide.
   assign trial = {rem_ff[CfgWidth-1:0], mag[CntWidth'(QW - 1) - count_ff]};
   assign take  = trial >= {1'b0, div_ff};

   // Floor quotient and grid index once the divide is done.
   always_comb begin
      fq = neg_ff ? -$signed({2'b00, quot_ff}) -
                    $signed({{(QW+1){1'b0}}, (rem_ff != '0)})
                  : $signed({2'b00, quot_ff});
      idx = HalfDim + fq;
      if (idx == -1) idx = '0;
      idx_ok   = (idx >= 0) && (idx < DimS);
      idx_bits = idx[IdxWidth-1:0];
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      axis_in  = axis_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      ix_in    = ix_ff;
      ok_in    = ok_ff;
      iz_in    = iz_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               item_in  = in_data;
               axis_in  = 1'b0;
               count_in = '0;
               quot_in  = '0;
               rem_in   = '0;
               div_in   = (edge_len == '0) ? CfgWidth'(1) : edge_len;
               neg_in   = in_data.point_x[15];
               ok_in    = 1'b1;
               state_in = (in_data.req_type == REQ_LOAD ||
                           in_data.req_type == REQ_CLASSIFY) ? ST_DIV : ST_OUT;
            end
         end
         ST_DIV: begin
            if (count_ff == CntWidth'(QW)) begin
               ok_in = ok_ff & idx_ok;
               if (!axis_ff) begin
                  ix_in    = idx_bits;
                  axis_in  = 1'b1;
                  count_in = '0;
                  quot_in  = '0;
                  rem_in   = '0;
                  neg_in   = item_ff.point_z[15];
               end else begin
                  iz_in    = idx_bits;
                  state_in = ST_OUT;
               end
            end else begin
               rem_in   = take ? trial - {1'b0, div_ff} : trial;
               quot_in  = {quot_ff[QW-2:0], take};
               count_in = count_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (cmd_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
      item_ff  <= item_in;
      axis_ff  <= axis_in;
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      neg_ff   <= neg_in;
      ix_ff    <= ix_in;
      ok_ff    <= ok_in;
      iz_ff    <= iz_in;
   end

endmodule

// ===== rtl/ghsoc_queue.sv =====
module ghsoc_queue
   import ghsoc_pkg::*;
#(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [Width-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [Width-1:0] rd_data
);

   // Two-entry queue between front and back end.
   logic [Width-1:0] slot_ff [2];
   logic [1:0]       fill_ff, fill_in;
   logic             head_ff, head_in;
   logic             push, pop;

   assign wr_ready = (fill_ff != 2'd2);
   assign rd_valid = (fill_ff != 2'd0);
   assign rd_data  = slot_ff[head_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;
   assign fill_in  = fill_ff + {1'b0, push} - {1'b0, pop};
   assign head_in  = head_ff ^ pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         head_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         head_ff <= head_in;
      end
      if (push) slot_ff[head_ff ^ fill_ff[0]] <= wr_data;
   end

endmodule

// ===== rtl/ghsoc_back.sv =====
module ghsoc_back
   import ghsoc_pkg::*;
#(
   parameter int GRID_DIM = 512,
   parameter int IdxWidth = $clog2(GRID_DIM)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CfgWidth-1:0]   threshold,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  cmd_base_type          cmd_base,
   input  logic [2*IdxWidth-1:0] cmd_cell,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rsp_payload_type       out_data
);

   localparam int CellWidth = 2 * IdxWidth;
   localparam int Cells     = 1 << CellWidth;
   localparam int EpWidth   = 8;
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_READ  = 4'd1;
   localparam logic [3:0] ST_EVAL  = 4'd2;
   localparam logic [3:0] ST_RESP  = 4'd3;
   localparam logic [3:0] ST_SWEEP = 4'd4;

   // Cell store: min, max and the frame epoch in which the cell was written.
   // Epoch zero never marks a valid cell; a wrap of the epoch sweeps the store.
   logic [31+EpWidth:0]  mem [Cells];
   logic [31+EpWidth:0]  rd_ff;
   logic                 we;
   logic [CellWidth-1:0] waddr;
   logic [31+EpWidth:0]  wdata;

   logic [3:0]           state_ff, state_in;
   cmd_base_type         cmd_ff, cmd_in;
   logic [CellWidth-1:0] cell_ff, cell_in;
   logic [EpWidth-1:0]   epoch_ff, epoch_in;
   logic [CellWidth-1:0] sweep_ff, sweep_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                 obs_ff, obs_in;
   logic                 ov_ff, ov_in;
   rsp_payload_type      od_ff, od_in;

   logic signed [15:0]   mn, mx;
   logic                 valid_cell;
   logic signed [16:0]   spread;

   assign mn         = rd_ff[31:16];
   assign mx         = rd_ff[15:0];
   assign valid_cell = (rd_ff[31+EpWidth:32] == epoch_ff);
   assign spread     = 17'(mx) - 17'(mn);
   assign cmd_ready  = (state_ff == ST_IDLE);
   assign out_valid  = ov_ff;
   assign out_data   = od_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      cell_in  = cell_ff;
      epoch_in = epoch_ff;
      sweep_in = sweep_ff;
      count_in = count_ff;
      obs_in   = obs_ff;
      ov_in    = ov_ff & ~out_ready;
      od_in    = od_ff;
      we       = 1'b0;
      waddr    = cell_ff;
      wdata    = {epoch_ff, cmd_ff.point_y, cmd_ff.point_y};
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in  = cmd_base;
               cell_in = cmd_cell;
               priority if (cmd_base.req_type == REQ_CLEAR) begin
                  count_in = '0;
                  if (epoch_ff == '1) begin
                     epoch_in = EpWidth'(1);
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end else if (cmd_base.req_type == REQ_CLASSIFY ||
                            (cmd_base.req_type == REQ_LOAD && cmd_base.in_grid)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (cmd_ff.req_type == REQ_LOAD) begin
               we = 1'b1;
               if (valid_cell) begin
                  wdata = {epoch_ff, (cmd_ff.point_y < mn) ? cmd_ff.point_y : mn,
                           (cmd_ff.point_y > mx) ? cmd_ff.point_y : mx};
               end
               state_in = ST_IDLE;
            end else begin
               obs_in   = cmd_ff.in_grid && valid_cell &&
                          (spread > $signed({3'b000, threshold}));
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // The result register is loaded only once the previous beat has gone.
            if (!ov_ff || out_ready) begin
               if (obs_ff && count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               od_in.is_obstacle    = obs_ff;
               od_in.out_x          = cmd_ff.point_x;
               od_in.out_y          = cmd_ff.point_y;
               od_in.out_z          = cmd_ff.point_z;
               od_in.obstacle_total = (obs_ff && count_ff != COUNT_MAX)
                                      ? count_ff + 1'b1 : count_ff;
               ov_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            we       = 1'b1;
            waddr    = sweep_ff;
            wdata    = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == CellWidth'(Cells - 1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         epoch_ff <= EpWidth'(1);
         sweep_ff <= '0;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         epoch_ff <= epoch_in;
         sweep_ff <= sweep_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
      cmd_ff  <= cmd_in;
      cell_ff <= cell_in;
      obs_ff  <= obs_in;
      od_ff   <= od_in;
   end

   // Store port: one write and one registered read.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[cell_ff];
   end

endmodule

// ===== rtl/ghsoc_checker.sv =====
module ghsoc_checker
   import ghsoc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A waiting request beat stays offered until taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before it was taken");

   // A result is held until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // A non-obstacle result never raises the count above the previous one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid && !rsp_data.is_obstacle |->
      rsp_data.obstacle_total <= $past(rsp_data.obstacle_total) ||
      rsp_data.obstacle_total == '0)
      else $error("count moved on a clear point");

   // An obstacle result carries a non-zero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_obstacle |-> rsp_data.obstacle_total != '0)
      else $error("obstacle with zero count");

endmodule

bind grid_height_spread_obstacle_classifier_core ghsoc_checker u_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
